@@ src/vbam_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbam_pkg: shared types, constants and helpers for the activity meter
// Register indexes, state types, clamping, rounding and saturation helpers.
// ----------------------------------------------------------------------------
package vbam_pkg;

  localparam int MaxChannels = 8;
  localparam int ChW         = $clog2(MaxChannels);
  localparam int CntW        = 4;

  localparam logic [16:0] Q16One = 17'd65536;

  typedef enum logic [2:0] {
    REG_HP_COEF   = 3'd0,
    REG_LP_COEF   = 3'd1,
    REG_PEAK_GAIN = 3'd2,
    REG_SMOOTH    = 3'd3,
    REG_SENS      = 3'd4,
    REG_ATTACK    = 3'd5,
    REG_DECAY     = 3'd6,
    REG_CHANNELS  = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_HP,
    ST_LP,
    ST_WR,
    ST_BE_RD,
    ST_BE_RAW,
    ST_BE_SM,
    ST_BE_DELTA,
    ST_BE_SQ1,
    ST_BE_SQ2,
    ST_BE_ENV,
    ST_BE_OUT,
    ST_CLR
  } state_e;

  // Per-channel filter state word
  typedef struct packed {
    logic signed [15:0] hp_in;
    logic signed [17:0] hp_out;
    logic signed [17:0] lp_out;
  } filt_t;

  // Per-channel level state word
  typedef struct packed {
    logic        primed;
    logic [16:0] smoothed;
    logic [16:0] env;
  } lvl_t;

  // Clamp a Q1.16 coefficient to one
  function automatic logic [16:0] unit_coef(input logic [16:0] c);
    unit_coef = (c > Q16One) ? Q16One : c;
  endfunction

  // Round a signed product by 2^16, ties away from zero
  function automatic logic signed [39:0] rnd16(input logic signed [39:0] v);
    logic [39:0] m;
    m = v[39] ? 40'(-v) : 40'(v);
    m = (m + 40'd32768) >> 16;
    rnd16 = v[39] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [39:0] v);
    if (v > 40'sd131071) sat18 = 18'sh1FFFF;
    else if (v < -40'sd131072) sat18 = 18'sh20000;
    else sat18 = v[17:0];
  endfunction

endpackage

@@ src/vbam_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbam_isqrt: bit-serial floor square root
// One result bit per cycle over a 34-bit radicand.
// ----------------------------------------------------------------------------
module vbam_isqrt
  import vbam_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [33:0] rad_i,
  output logic             done_o,
  output logic [16:0]      root_o
);

  logic [33:0] rem_q, rem_d;
  logic [33:0] rad_q, rad_d;
  logic [16:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [35:0] trial;
  logic [35:0] remsh;

  // One restoring step per cycle
  always_comb begin
    rem_d  = rem_q;
    rad_d  = rad_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    remsh  = {rem_q, rad_q[33:32]};
    trial  = {17'd0, root_q, 2'b01};
    if (start_i) begin
      rem_d  = '0;
      rad_d  = rad_i;
      root_d = '0;
      cnt_d  = 5'd17;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[31:0], 2'b00};
      if (remsh >= trial) begin
        rem_d  = 34'(remsh - trial);
        root_d = {root_q[15:0], 1'b1};
      end else begin
        rem_d  = remsh[33:0];
        root_d = {root_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    rad_q  <= rad_d;
    root_q <= root_d;
  end

  // Final root is valid in the done cycle, even when a new start is taken
  assign done_o = busy_q && (cnt_q == 5'd1);
  assign root_o = {root_q[15:0], (remsh >= trial)};

`ifndef SYNTHESIS
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != 5'd0))
    else $error("isqrt busy with zero count");
  a_done_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !start_i) |=> !busy_q)
    else $error("isqrt still busy after done");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (busy_q && cnt_q == 5'd17))
    else $error("isqrt did not start");
`endif

endmodule
`default_nettype wire

@@ src/voice_band_activity_meter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a plain sample steps through memory read, high-pass, low-pass, write;
//   inactive channels skip the filter steps. Block end: after the sample, each active
//   channel takes two passes through the bit-serial square root and may wait on
//   output stalls; peak memory is then cleared. One sample in flight at a time.
// Reset: asynchronous, active low; config and control registers take their reset
//   values and the channel state reads as zero through per-channel valid bits.
// ----------------------------------------------------------------------------
// voice_band_activity_meter_top: per-channel filtering and activity levels
// Filter and level state live in small memories, read-modify-write per item.
// ----------------------------------------------------------------------------
module voice_band_activity_meter_top
  import vbam_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         channel_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               block_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              out_channel_o,
  output logic [16:0]             activity_level_o,
  output logic                    last_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [16:0]        cfg_data_i
);

  // Configuration registers
  logic [16:0] hp_coef_q, lp_coef_q, smooth_q, attack_q, decay_q;
  logic [15:0] gain_q, sens_q;
  logic [3:0]  chans_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_coef_q <= 17'd58911;
      lp_coef_q <= 17'd20914;
      gain_q    <= 16'd16384;
      smooth_q  <= 17'd6554;
      sens_q    <= 16'd12800;
      attack_q  <= 17'd65536;
      decay_q   <= 17'd22746;
      chans_q   <= 4'd2;
    end else if (cfg_we) begin
      case (reg_idx_e'(cfg_index_i))
        REG_HP_COEF:   hp_coef_q <= cfg_data_i;
        REG_LP_COEF:   lp_coef_q <= cfg_data_i;
        REG_PEAK_GAIN: gain_q    <= cfg_data_i[15:0];
        REG_SMOOTH:    smooth_q  <= cfg_data_i;
        REG_SENS:      sens_q    <= cfg_data_i[15:0];
        REG_ATTACK:    attack_q  <= cfg_data_i;
        REG_DECAY:     decay_q   <= cfg_data_i;
        REG_CHANNELS:  chans_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic filt_clear;
  assign filt_clear = cfg_we && (cfg_index_i == REG_HP_COEF || cfg_index_i == REG_LP_COEF);

  logic [3:0] count;
  assign count = (chans_q > 4'(MaxChannels)) ? 4'(MaxChannels) : chans_q;

  // State memories with valid bits
  filt_t       filt_mem [MaxChannels];
  lvl_t        lvl_mem  [MaxChannels];
  logic [16:0] peak_mem [MaxChannels];
  logic [MaxChannels-1:0] fvalid_q, lvalid_q, pvalid_q;

  filt_t       filt_rd_q, filt_rd;
  lvl_t        lvl_rd_q, lvl_rd;
  logic [16:0] peak_rd_q, peak_rd;
  logic [ChW-1:0] rd_addr;
  logic        filt_we, lvl_we, peak_we, peak_clr;
  filt_t       filt_wd;
  lvl_t        lvl_wd;
  logic [16:0] peak_wd;
  logic        frd_v_q, lrd_v_q, prd_v_q;

  // Session registers
  state_e         state_q, state_d;
  logic [ChW-1:0] ch_q, ch_d;
  logic           be_q, be_d, act_q, act_d;
  logic signed [15:0] x_q, x_d;
  logic signed [17:0] hp_q, hp_d, lp_q, lp_d;
  logic [16:0] raw_q, raw_d, prev_q, prev_d, nsm_q, nsm_d, delta_q, delta_d;
  logic [16:0] tgt_q, tgt_d, env_q, env_d;
  logic [3:0]  walk_q, walk_d;
  logic        ovalid_q, ovalid_d, olast_q, olast_d;
  logic [2:0]  och_q, och_d;
  logic [16:0] olvl_q, olvl_d;

  logic        sq_start, sq_done;
  logic [33:0] sq_rad;
  logic [16:0] sq_root;

  vbam_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (sq_rad),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  always_ff @(posedge clk_i) begin
    filt_rd_q <= filt_mem[rd_addr];
    lvl_rd_q  <= lvl_mem[rd_addr];
    peak_rd_q <= peak_mem[rd_addr];
    if (filt_we) filt_mem[ch_q] <= filt_wd;
    if (lvl_we)  lvl_mem[walk_q[ChW-1:0]] <= lvl_wd;
    if (peak_we) peak_mem[ch_q] <= peak_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q <= '0;
      lvalid_q <= '0;
      pvalid_q <= '0;
      frd_v_q  <= 1'b0;
      lrd_v_q  <= 1'b0;
      prd_v_q  <= 1'b0;
    end else begin
      frd_v_q <= fvalid_q[rd_addr];
      lrd_v_q <= lvalid_q[rd_addr];
      prd_v_q <= pvalid_q[rd_addr];
      if (filt_clear) fvalid_q <= '0;
      else if (filt_we) fvalid_q[ch_q] <= 1'b1;
      if (lvl_we) lvalid_q[walk_q[ChW-1:0]] <= 1'b1;
      if (peak_clr) pvalid_q <= '0;
      else if (peak_we) pvalid_q[ch_q] <= 1'b1;
    end
  end

  assign filt_rd = frd_v_q ? filt_rd_q : '0;
  assign lvl_rd  = lrd_v_q ? lvl_rd_q : '0;
  assign peak_rd = prd_v_q ? peak_rd_q : '0;

  // Datapath helpers
  logic signed [19:0] hsum;
  logic signed [39:0] hprod, lprod, sprod, eprod;
  logic signed [18:0] ldiff;
  logic [17:0]        lmag;
  logic [32:0]        gprod;
  logic [16:0]        rawc;
  logic signed [17:0] sdiff, ediff;
  logic [16:0]        adiff;
  logic [32:0]        dprod;
  logic [24:0]        dr;
  logic [16:0]        kc;
  logic signed [39:0] envn;
  logic [16:0]        env_cur;

  assign hsum  = 20'(filt_rd.hp_out) + 20'(x_q) - 20'(filt_rd.hp_in);
  assign hprod = 40'(hsum) * $signed({1'b0, unit_coef(hp_coef_q)});
  assign ldiff = 19'(hp_q) - 19'(filt_rd.lp_out);
  assign lprod = 40'(ldiff) * $signed({1'b0, unit_coef(lp_coef_q)});
  assign lmag  = lp_q[17] ? 18'(-19'(lp_q)) : 18'(lp_q);
  assign gprod = peak_rd * gain_q;
  assign rawc  = ((gprod + 33'd1024) >> 11) > 33'(Q16One) ? Q16One
               : 17'((gprod + 33'd1024) >> 11);
  assign sdiff = $signed({1'b0, raw_q}) - $signed({1'b0, prev_q});
  assign sprod = 40'(sdiff) * $signed({1'b0, unit_coef(smooth_q)});
  assign adiff = (nsm_q >= prev_q) ? 17'(nsm_q - prev_q) : 17'(prev_q - nsm_q);
  assign dprod = adiff * sens_q;
  assign dr    = 25'((dprod + 33'd128) >> 8);
  assign env_cur = lvl_rd.env;
  assign ediff = $signed({1'b0, tgt_q}) - $signed({1'b0, env_q});
  assign kc    = unit_coef((tgt_q > env_q) ? attack_q : decay_q);
  assign eprod = 40'(ediff) * $signed({1'b0, kc});
  assign envn  = 40'($signed({1'b0, env_q})) + rnd16(eprod);

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    be_d     = be_q;
    act_d    = act_q;
    x_d      = x_q;
    hp_d     = hp_q;
    lp_d     = lp_q;
    raw_d    = raw_q;
    prev_d   = prev_q;
    nsm_d    = nsm_q;
    delta_d  = delta_q;
    tgt_d    = tgt_q;
    env_d    = env_q;
    walk_d   = walk_q;
    ovalid_d = ovalid_q;
    olast_d  = olast_q;
    och_d    = och_q;
    olvl_d   = olvl_q;
    rd_addr  = ch_q;
    filt_we  = 1'b0;
    lvl_we   = 1'b0;
    peak_we  = 1'b0;
    peak_clr = 1'b0;
    filt_wd  = '0;
    lvl_wd   = '0;
    peak_wd  = '0;
    sq_start = 1'b0;
    sq_rad   = '0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ch_d    = channel_i;
          x_d     = sample_i;
          be_d    = block_end_i;
          act_d   = ({1'b0, channel_i} < count);
          rd_addr = channel_i;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = act_q ? ST_HP : ST_WR;
      end
      ST_HP: begin
        hp_d    = sat18(rnd16(hprod));
        state_d = ST_LP;
      end
      ST_LP: begin
        lp_d    = sat18(40'(filt_rd.lp_out) + rnd16(lprod));
        state_d = ST_WR;
      end
      ST_WR: begin
        if (act_q) begin
          filt_we = 1'b1;
          filt_wd = '{hp_in: x_q, hp_out: hp_q, lp_out: lp_q};
          peak_we = 1'b1;
          peak_wd = ((lmag > 18'd131071) ? 17'h1FFFF : lmag[16:0]) > peak_rd
                  ? ((lmag > 18'd131071) ? 17'h1FFFF : lmag[16:0]) : peak_rd;
        end
        walk_d = '0;
        if (!be_q) state_d = ST_IDLE;
        else state_d = (count == 4'd0) ? ST_CLR : ST_BE_RD;
      end
      ST_BE_RD: begin
        rd_addr = walk_q[ChW-1:0];
        state_d = ST_BE_RAW;
      end
      ST_BE_RAW: begin
        // keep the walked channel on the read port for the smoothing step
        rd_addr = walk_q[ChW-1:0];
        raw_d   = rawc;
        env_d   = env_cur;
        state_d = ST_BE_SM;
      end
      ST_BE_SM: begin
        prev_d  = lvl_rd.primed ? lvl_rd.smoothed : raw_q;
        state_d = ST_BE_DELTA;
      end
      ST_BE_DELTA: begin
        nsm_d    = 17'(40'($signed({1'b0, prev_q})) + rnd16(sprod));
        state_d  = ST_BE_SQ1;
        // nsm is used next cycle; start of root waits until delta known
      end
      ST_BE_SQ1: begin
        delta_d  = (dr > 25'(Q16One)) ? Q16One : dr[16:0];
        sq_start = 1'b1;
        sq_rad   = 34'((dr > 25'(Q16One)) ? Q16One : dr[16:0]) << 16;
        state_d  = ST_BE_SQ2;
      end
      ST_BE_SQ2: begin
        if (sq_done) begin
          sq_start = 1'b1;
          sq_rad   = 34'(delta_q) * 34'(sq_root);
          state_d  = ST_BE_ENV;
        end
      end
      ST_BE_ENV: begin
        if (sq_done) begin
          tgt_d   = sq_root;
          state_d = ST_BE_OUT;
        end
      end
      ST_BE_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          if (envn < 0) env_d = '0;
          else if (envn > 40'sd65536) env_d = Q16One;
          else env_d = envn[16:0];
          lvl_we   = 1'b1;
          lvl_wd   = '{primed: 1'b1, smoothed: nsm_q, env: env_d};
          ovalid_d = 1'b1;
          och_d    = walk_q[2:0];
          olvl_d   = env_d;
          olast_d  = (walk_q + 4'd1 == count);
          walk_d   = walk_q + 4'd1;
          state_d  = (walk_q + 4'd1 == count) ? ST_CLR : ST_BE_RD;
        end
      end
      ST_CLR: begin
        peak_clr = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      walk_q   <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      walk_q   <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    be_q    <= be_d;
    act_q   <= act_d;
    x_q     <= x_d;
    hp_q    <= hp_d;
    lp_q    <= lp_d;
    raw_q   <= raw_d;
    prev_q  <= prev_d;
    nsm_q   <= nsm_d;
    delta_q <= delta_d;
    tgt_q   <= tgt_d;
    env_q   <= env_d;
    olast_q <= olast_d;
    och_q   <= och_d;
    olvl_q  <= olvl_d;
  end

  assign out_valid_o      = ovalid_q;
  assign out_channel_o    = och_q;
  assign activity_level_o = olvl_q;
  assign last_o           = olast_q;

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (activity_level_o <= Q16One))
    else $error("activity level above one");
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_channel_o} < count))
    else $error("reported channel out of range");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input accepted while busy");
  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |=> (state_q == ST_IDLE && pvalid_q == '0))
    else $error("peak clear did not complete");
`endif

endmodule
`default_nettype wire
